[hw/rtl/bfrgb_pkg.sv]
// Package for the 3x3 RGB box filter: sizes, result codes, queue entry type.
// No dependencies; imported by every module of the block but bfrgb_ram.
`timescale 1ns / 1ps
`default_nettype none

package bfrgb_pkg;

	localparam int unsigned MAX_WIDTH = 512;
	localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
	localparam int unsigned ROW_W     = 12;
	localparam int unsigned CFG_WW    = 10;
	localparam int unsigned CFG_HW    = 12;
	localparam int unsigned MIN_DIM   = 3;
	localparam int unsigned QDEPTH    = 4;

	localparam logic [CFG_WW-1:0] WIDTH_RST  = CFG_WW'(512);
	localparam logic [CFG_HW-1:0] HEIGHT_RST = CFG_HW'(384);

	// mean of nine: sum * 7282 >> 16 is exact for sums up to 9*255
	localparam int unsigned SUM_W       = 12;
	localparam int unsigned RECIP_W     = 13;
	localparam int unsigned RECIP_SHIFT = 16;
	localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(7282);

	// register indexes on the APB port
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// result slots one input can release, in emission order
	localparam int unsigned RES_CUR  = 0;  // pixel (r-1, c-1)
	localparam int unsigned RES_EOL  = 1;  // end of row, pixel (r-1, W-1)
	localparam int unsigned RES_BOT  = 2;  // bottom row, pixel (H-1, c-1)
	localparam int unsigned RES_LAST = 3;  // frame corner, pixel (H-1, W-1)
	localparam int unsigned NRES     = 4;

	typedef logic [23:0] pix_t;  // R[23:16] G[15:8] B[7:0]

	typedef struct packed {
		pix_t             px;
		pix_t             up;
		pix_t             mid;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             filt;
		logic [NRES-1:0]  emit;
	} qent_t;

endpackage

`default_nettype wire

[hw/rtl/bfrgb_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bfrgb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/bfrgb_front.sv]
// Front end: raster counters, item classification, line buffer read/write.
// Depends on bfrgb_pkg and bfrgb_ram; feeds bfrgb_fifo.
`timescale 1ns / 1ps
`default_nettype none

module bfrgb_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        restart,
	input  wire logic [bfrgb_pkg::CFG_WW-1:0] frame_width,
	input  wire logic [bfrgb_pkg::CFG_HW-1:0] frame_height,
	input  wire logic                        pix_valid,
	output logic                             pix_stall,
	input  wire logic [7:0]                  red_in,
	input  wire logic [7:0]                  green_in,
	input  wire logic [7:0]                  blue_in,
	input  wire logic                        q_full,
	output logic                             push,
	output bfrgb_pkg::qent_t                 push_data
);
	import bfrgb_pkg::*;

	logic [CFG_WW-1:0] eff_w;
	logic [CFG_HW-1:0] eff_h;
	logic [CFG_WW-1:0] w_dec;
	logic [COL_W-1:0]  wm1;
	logic [ROW_W-1:0]  hm1;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              accept;

	logic              valid_s1;
	pix_t              px_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              filt_s1;
	logic [NRES-1:0]   emit_s1;

	logic              c_ge1, c_ge2, r_ge1, r_ge2, last_col, last_row;
	logic [47:0]       line_rd;

	always_comb begin
		eff_w = frame_width;
		if (frame_width < CFG_WW'(MIN_DIM)) begin
			eff_w = CFG_WW'(MIN_DIM);
		end else if (frame_width > CFG_WW'(MAX_WIDTH)) begin
			eff_w = CFG_WW'(MAX_WIDTH);
		end
		eff_h = frame_height;
		if (frame_height < CFG_HW'(MIN_DIM)) begin
			eff_h = CFG_HW'(MIN_DIM);
		end
	end

	assign w_dec = eff_w - CFG_WW'(1);
	assign wm1   = w_dec[COL_W-1:0];
	assign hm1   = ROW_W'(eff_h - CFG_HW'(1));

	assign pix_stall = valid_s1 && q_full;
	assign accept    = pix_valid && !pix_stall;
	assign push      = valid_s1 && !q_full;

	assign c_ge1    = col_q != '0;
	assign c_ge2    = col_q > COL_W'(1);
	assign r_ge1    = row_q != '0;
	assign r_ge2    = row_q > ROW_W'(1);
	assign last_col = col_q == wm1;
	assign last_row = row_q == hm1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1             <= {red_in, green_in, blue_in};
			col_s1            <= col_q;
			row_s1            <= row_q;
			filt_s1           <= r_ge2 && c_ge2;
			emit_s1[RES_CUR]  <= r_ge1 && c_ge1;
			emit_s1[RES_EOL]  <= r_ge1 && last_col;
			emit_s1[RES_BOT]  <= last_row && c_ge1;
			emit_s1[RES_LAST] <= last_row && last_col;
		end
	end

	// {upper, middle} per column; read on accept, rewritten when the item leaves
	bfrgb_ram #(
		.WIDTH(48),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk  (clk),
		.we   (push),
		.waddr(col_s1),
		.wdata({line_rd[23:0], px_s1}),
		.re   (accept),
		.raddr(col_q),
		.rdata(line_rd)
	);

	always_comb begin
		push_data.px   = px_s1;
		push_data.up   = line_rd[47:24];
		push_data.mid  = line_rd[23:0];
		push_data.row  = row_s1;
		push_data.col  = col_s1;
		push_data.filt = filt_s1;
		push_data.emit = emit_s1;
	end

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= wm1) else $error("column counter past row end");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= hm1) else $error("row counter past frame end");

endmodule

`default_nettype wire

[hw/rtl/bfrgb_fifo.sv]
// Short queue of classified items between front and back end.
// Depends on bfrgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfrgb_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  bfrgb_pkg::qent_t      push_data,
	output logic                  full,
	input  wire logic             pop,
	output bfrgb_pkg::qent_t      pop_data,
	output logic                  avail
);
	import bfrgb_pkg::*;

	localparam int unsigned PTR_W = $clog2(QDEPTH);
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	qent_t             mem_q [QDEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push, do_pop;

	assign full     = cnt_q == CNT_W'(QDEPTH);
	assign avail    = cnt_q != '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && avail;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QDEPTH)) else $error("queue count overflow");

endmodule

`default_nettype wire

[hw/rtl/bfrgb_back.sv]
// Back end: 3x3 window, per-channel sums, divide by nine, result sequencer.
// Depends on bfrgb_pkg; fed by bfrgb_fifo.
`timescale 1ns / 1ps
`default_nettype none

module bfrgb_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       restart,
	input  wire logic                       avail,
	input  bfrgb_pkg::qent_t                entry,
	output logic                            pop,
	output logic                            res_valid,
	input  wire logic                       res_stall,
	output logic [7:0]                      red_out,
	output logic [7:0]                      green_out,
	output logic [7:0]                      blue_out,
	output logic [bfrgb_pkg::ROW_W-1:0]     row_index,
	output logic [bfrgb_pkg::COL_W-1:0]     column_index,
	output logic                            frame_done,
	output logic                            last_of_run
);
	import bfrgb_pkg::*;

	localparam int unsigned PROD_W = SUM_W + RECIP_W;

	pix_t              win_q [6];
	pix_t              nb [9];
	logic [SUM_W-1:0]  sum_c [3];

	// stage 2: sums and candidate results
	logic              valid_s2;
	logic [SUM_W-1:0]  sum_s2 [3];
	pix_t              pa_s2, pb_s2, pc_s2, pd_s2;
	logic              filt_s2;
	logic [NRES-1:0]   emit_s2;
	logic [ROW_W-1:0]  row_s2;
	logic [COL_W-1:0]  col_s2;

	// stage 3: final values, results still to send
	logic              valid_s3;
	pix_t              pa_s3, pb_s3, pc_s3, pd_s3;
	logic [NRES-1:0]   emit_s3;
	logic [ROW_W-1:0]  row_s3;
	logic [COL_W-1:0]  col_s3;

	logic [PROD_W-1:0] prod [3];
	pix_t              mean_c;

	logic              out_free, take, s3_finish, s3_ready, s2_ready;
	logic [NRES-1:0]   rest;
	pix_t              sel_pix;
	logic [ROW_W-1:0]  sel_row;
	logic [COL_W-1:0]  sel_col;
	logic              sel_done;

	logic              res_valid_q;
	pix_t              res_pix_q;
	logic [ROW_W-1:0]  res_row_q;
	logic [COL_W-1:0]  res_col_q;
	logic              res_done_q, res_last_q;

	assign out_free  = !res_valid_q || !res_stall;
	assign take      = valid_s3 && (emit_s3 != '0) && out_free;
	assign s3_finish = valid_s3 && ((emit_s3 == '0) || (out_free && rest == '0));
	assign s3_ready  = !valid_s3 || s3_finish;
	assign s2_ready  = !valid_s2 || s3_ready;
	assign pop       = avail && s2_ready;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			nb[i] = win_q[i];
		end
		nb[6] = entry.up;
		nb[7] = entry.mid;
		nb[8] = entry.px;
		for (int k = 0; k < 3; k++) begin
			sum_c[k] = '0;
			for (int i = 0; i < 9; i++) begin
				sum_c[k] = sum_c[k] + SUM_W'(nb[i][8*k +: 8]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (restart) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (pop) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= entry.up;
			win_q[4] <= entry.mid;
			win_q[5] <= entry.px;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s2_ready) begin
				valid_s2 <= pop;
			end
			if (s3_ready) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int k = 0; k < 3; k++) begin
				sum_s2[k] <= sum_c[k];
			end
			pa_s2   <= win_q[4];
			pb_s2   <= entry.mid;
			pc_s2   <= win_q[5];
			pd_s2   <= entry.px;
			filt_s2 <= entry.filt;
			emit_s2 <= entry.emit;
			row_s2  <= entry.row;
			col_s2  <= entry.col;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k] = PROD_W'(sum_s2[k]) * PROD_W'(RECIP9);
			mean_c[8*k +: 8] = prod[k][RECIP_SHIFT +: 8];
		end
	end

	always_ff @(posedge clk) begin
		if (s3_ready && valid_s2) begin
			pa_s3   <= filt_s2 ? mean_c : pa_s2;
			pb_s3   <= pb_s2;
			pc_s3   <= pc_s2;
			pd_s3   <= pd_s2;
			emit_s3 <= emit_s2;
			row_s3  <= row_s2;
			col_s3  <= col_s2;
		end else if (take) begin
			emit_s3 <= rest;
		end
	end

	// pick the next pending result in emission order
	always_comb begin
		rest     = emit_s3;
		sel_pix  = pd_s3;
		sel_row  = row_s3;
		sel_col  = col_s3;
		sel_done = 1'b0;
		if (emit_s3[RES_CUR]) begin
			rest[RES_CUR] = 1'b0;
			sel_pix       = pa_s3;
			sel_row       = row_s3 - ROW_W'(1);
			sel_col       = col_s3 - COL_W'(1);
		end else if (emit_s3[RES_EOL]) begin
			rest[RES_EOL] = 1'b0;
			sel_pix       = pb_s3;
			sel_row       = row_s3 - ROW_W'(1);
		end else if (emit_s3[RES_BOT]) begin
			rest[RES_BOT] = 1'b0;
			sel_pix       = pc_s3;
			sel_col       = col_s3 - COL_W'(1);
		end else begin
			rest[RES_LAST] = 1'b0;
			sel_done       = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_pix_q  <= sel_pix;
			res_row_q  <= sel_row;
			res_col_q  <= sel_col;
			res_done_q <= sel_done;
			res_last_q <= rest == '0;
		end
	end

	assign res_valid    = res_valid_q;
	assign red_out      = res_pix_q[23:16];
	assign green_out    = res_pix_q[15:8];
	assign blue_out     = res_pix_q[7:0];
	assign row_index    = res_row_q;
	assign column_index = res_col_q;
	assign frame_done   = res_done_q;
	assign last_of_run  = res_last_q;

	a_corner_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && emit_s2[RES_LAST] |->
			emit_s2[RES_CUR] && emit_s2[RES_EOL] && emit_s2[RES_BOT])
		else $error("frame corner without its companion results");
	a_filt_emits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && filt_s2 |-> emit_s2[RES_CUR])
		else $error("filtered item with no current result");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_done_q |-> res_last_q)
		else $error("frame_done on a beat that is not last of run");

endmodule

`default_nettype wire

[hw/rtl/box_filter_3x3_rgb.sv]
// Top level of the streaming 3x3 RGB mean filter: APB registers and wiring.
// Depends on bfrgb_pkg, bfrgb_front, bfrgb_fifo, bfrgb_back (and bfrgb_ram).
//
//   channel   handshake              beat contents
//   pixel     pix_valid / pix_stall  red_in, green_in, blue_in (raster order)
//   result    res_valid / res_stall  red_out, green_out, blue_out, row_index,
//                                    column_index, frame_done, last_of_run
//   config    APB psel/penable       frame_width @0x0, frame_height @0x4
//
// Pixels go in one per clock while the queue has room; the result sequencer
// sends one beat per clock while res_stall is low, so a row-end
// pixel from row 1 on gives two beats, every other bottom-row pixel from column
// 1 on gives two, and the frame's last pixel gives four. Before its first
// result beat a pixel passes line-buffer read, queue, sum stage, divide stage
// and result register. Reset clears counters, window and pipeline valids; line
// buffers are not cleared since a frame only uses columns it has already
// written. A stalled result holds in the output register while the four-entry
// queue keeps the front taking pixels; a register write restarts the frame.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_3x3_rgb (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// APB configuration
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [2:0]              paddr,
	input  wire logic [31:0]             pwdata,
	output logic      [31:0]             prdata,
	output logic                         pready,
	// pixel input
	input  wire logic                    pix_valid,
	output logic                         pix_stall,
	input  wire logic [7:0]              red_in,
	input  wire logic [7:0]              green_in,
	input  wire logic [7:0]              blue_in,
	// result output
	output logic                         res_valid,
	input  wire logic                    res_stall,
	output logic [7:0]                   red_out,
	output logic [7:0]                   green_out,
	output logic [7:0]                   blue_out,
	output logic [bfrgb_pkg::ROW_W-1:0]  row_index,
	output logic [bfrgb_pkg::COL_W-1:0]  column_index,
	output logic                         frame_done,
	output logic                         last_of_run
);
	import bfrgb_pkg::*;

	logic [CFG_WW-1:0] frame_width_q;
	logic [CFG_HW-1:0] frame_height_q;
	logic              cfg_wr;
	logic              reg_sel;

	logic              q_push, q_full, q_pop, q_avail;
	qent_t             q_in, q_out;

	// registers sit at 4*index; paddr[2] is the index
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RST;
			frame_height_q <= HEIGHT_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_WIDTH:  frame_width_q  <= pwdata[CFG_WW-1:0];
				REG_HEIGHT: frame_height_q <= pwdata[CFG_HW-1:0];
				default:    frame_width_q  <= frame_width_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_WIDTH:  prdata = 32'(frame_width_q);
			REG_HEIGHT: prdata = 32'(frame_height_q);
			default:    prdata = '0;
		endcase
	end

	// front: counters, classification, line buffers
	bfrgb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (cfg_wr),
		.frame_width (frame_width_q),
		.frame_height(frame_height_q),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.q_full      (q_full),
		.push        (q_push),
		.push_data   (q_in)
	);

	// decouples front pacing from result-beat pacing
	bfrgb_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_out),
		.avail    (q_avail)
	);

	// back: window, mean, result sequencing
	bfrgb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (cfg_wr),
		.avail       (q_avail),
		.entry       (q_out),
		.pop         (q_pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.row_index   (row_index),
		.column_index(column_index),
		.frame_done  (frame_done),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

[tb/box_filter_3x3_rgb_tb.sv]
// Self-checking bench for box_filter_3x3_rgb: random and directed RGB frames,
// predicted beat by beat against a behavioral 3x3 mean filter kept in this file.
// Depends on bfrgb_pkg and the box_filter_3x3_rgb RTL only.
`timescale 1ns / 1ps

module box_filter_3x3_rgb_tb;
	import bfrgb_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 16;   // outlasts the pipe latency, covers silent row-0 beats
	localparam int BUSY_PCT     = 54;
	localparam int BOTH_PCT     = 9;
	localparam int RANDOM_PIXELS = 240;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// one output beat as the block should present it
	typedef struct packed {
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             done;
		logic             last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;

	logic        pix_valid = 1'b0;
	wire         pix_stall;
	logic [7:0]  red_in = '0;
	logic [7:0]  green_in = '0;
	logic [7:0]  blue_in = '0;

	wire              res_valid;
	logic             res_stall = 1'b0;
	wire [7:0]        red_out;
	wire [7:0]        green_out;
	wire [7:0]        blue_out;
	wire [ROW_W-1:0]  row_index;
	wire [COL_W-1:0]  column_index;
	wire              frame_done;
	wire              last_of_run;

	box_filter_3x3_rgb dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.red_in       (red_in),
		.green_in     (green_in),
		.blue_in      (blue_in),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out),
		.row_index    (row_index),
		.column_index (column_index),
		.frame_done   (frame_done),
		.last_of_run  (last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow filter: own copy of the line buffers, window and position.
	// ------------------------------------------------------------------
	logic [9:0]  width_reg = 10'(512);
	logic [11:0] height_reg = 12'(384);
	pix_t        upper_mem [MAX_WIDTH];
	pix_t        middle_mem [MAX_WIDTH];
	pix_t        win [6];       // 0..2: column c-2 rows r-2..r, 3..5: column c-1
	int          row_pos = 0;
	int          col_pos = 0;

	pix_t        pixel_q [$];   // pixels waiting to be driven
	result_t     filtered_q [$];  // beats the block owes us, oldest first

	idle_mode_t  idle_mode = IDLE_NONE;
	int          errors = 0;
	int          pixels_sent = 0;
	int          beats_checked = 0;
	int          settings_used = 0;
	int          cycles = 0;

	function automatic pix_t box_mean(input pix_t nb [9]);
		int   sum;
		pix_t res;
		for (int ch = 0; ch < 3; ch++) begin
			sum = 0;
			for (int k = 0; k < 9; k++)
				sum += int'(nb[k][8*ch +: 8]);
			res[8*ch +: 8] = 8'(sum / 9);
		end
		return res;
	endfunction

	function automatic result_t make_beat(input pix_t px, input int row, input int col,
			input logic done);
		result_t b;
		b.red   = px[23:16];
		b.green = px[15:8];
		b.blue  = px[7:0];
		b.row   = ROW_W'(row);
		b.col   = COL_W'(col);
		b.done  = done;
		b.last  = 1'b0;
		return b;
	endfunction

	// Advance the shadow filter by one accepted pixel and queue what it releases.
	task automatic filter_pixel(input pix_t px);
		int      w, h, r, c, n;
		pix_t    up, mid, val;
		pix_t    nb [9];
		result_t outs [4];
		w = int'(width_reg);
		if (w < MIN_DIM) w = MIN_DIM;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		h = int'(height_reg);
		if (h < MIN_DIM) h = MIN_DIM;
		r = row_pos;
		c = col_pos;
		if (c >= w) c = 0;
		if (r >= h) r = 0;
		up  = upper_mem[c];
		mid = middle_mem[c];
		n = 0;
		// centre of the window, one row and one column behind the input
		if (r >= 1 && c >= 1) begin
			val = win[4];
			if (r >= 2 && c >= 2) begin
				for (int k = 0; k < 6; k++)
					nb[k] = win[k];
				nb[6] = up;
				nb[7] = mid;
				nb[8] = px;
				val = box_mean(nb);
			end
			outs[n] = make_beat(val, r - 1, c - 1, 1'b0);
			n++;
		end
		// right border of the row above
		if (r >= 1 && c == w - 1) begin
			outs[n] = make_beat(mid, r - 1, c, 1'b0);
			n++;
		end
		// bottom row flushes as it arrives
		if (r == h - 1 && c >= 1) begin
			outs[n] = make_beat(win[5], r, c - 1, 1'b0);
			n++;
		end
		if (r == h - 1 && c == w - 1) begin
			outs[n] = make_beat(px, r, c, 1'b1);
			n++;
		end
		for (int k = 0; k < n; k++) begin
			outs[k].last = (k == n - 1);
			filtered_q.push_back(outs[k]);
		end
		upper_mem[c]  = mid;
		middle_mem[c] = px;
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = up;
		win[4] = mid;
		win[5] = px;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// ------------------------------------------------------------------
	// Pixel driver: holds a stalled beat, otherwise pulls the next pixel
	// unless the current idle pattern asks for a gap.
	// ------------------------------------------------------------------
	function automatic bit sender_gap();
		case (idle_mode)
			IDLE_SEND: return $urandom_range(99) < BUSY_PCT;
			IDLE_BOTH: return $urandom_range(99) < BOTH_PCT;
			default:   return 1'b0;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_valid && !pix_stall) begin
				filter_pixel({red_in, green_in, blue_in});
				pixels_sent++;
			end
			if (!pix_valid || !pix_stall) begin
				if (pixel_q.size() > 0 && !sender_gap()) begin
					pix_valid <= 1'b1;
					{red_in, green_in, blue_in} <= pixel_q.pop_front();
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// Result side back-pressure follows the same idle pattern.
	always @(posedge clk) begin
		if (!arst_n)
			res_stall <= 1'b0;
		else if (idle_mode == IDLE_RECV)
			res_stall <= $urandom_range(99) < BUSY_PCT;
		else if (idle_mode == IDLE_BOTH)
			res_stall <= $urandom_range(99) < BOTH_PCT;
		else
			res_stall <= 1'b0;
	end

	// ------------------------------------------------------------------
	// Monitor: every accepted result beat is matched against the oldest
	// predicted beat, field by field.
	// ------------------------------------------------------------------
	result_t head;

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (filtered_q.size() == 0) begin
				$error("unexpected result beat: row %0d column %0d", row_index, column_index);
				errors++;
			end else begin
				head = filtered_q.pop_front();
				check_field("red_out", 32'(head.red), 32'(red_out));
				check_field("green_out", 32'(head.green), 32'(green_out));
				check_field("blue_out", 32'(head.blue), 32'(blue_out));
				check_field("row_index", 32'(head.row), 32'(row_index));
				check_field("column_index", 32'(head.col), 32'(column_index));
				check_field("frame_done", 32'(head.done), 32'(frame_done));
				check_field("last_of_run", 32'(head.last), 32'(last_of_run));
				beats_checked++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still owed", cycles,
				filtered_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	task automatic apb_xfer(input logic wr, input logic [2:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Program both sizes (block must be idle), read them back, restart shadow frame.
	task automatic set_frame(input logic [9:0] w, input logic [11:0] h);
		logic [31:0] rd;
		apb_xfer(1'b1, {REG_WIDTH, 2'b00}, 32'(w), rd);
		apb_xfer(1'b1, {REG_HEIGHT, 2'b00}, 32'(h), rd);
		apb_xfer(1'b0, {REG_WIDTH, 2'b00}, '0, rd);
		check_field("frame_width readback", 32'(w), rd);
		apb_xfer(1'b0, {REG_HEIGHT, 2'b00}, '0, rd);
		check_field("frame_height readback", 32'(h), rd);
		width_reg  = w;
		height_reg = h;
		for (int k = 0; k < 6; k++)
			win[k] = '0;
		row_pos = 0;
		col_pos = 0;
		settings_used++;
	endtask

	// Mostly random pixels, with all-dark and all-bright ones mixed in.
	task automatic queue_random(input int count);
		int sel;
		for (int k = 0; k < count; k++) begin
			sel = int'($urandom_range(7));
			if (sel == 0)
				pixel_q.push_back(24'h000000);
			else if (sel == 1)
				pixel_q.push_back(24'hFFFFFF);
			else
				pixel_q.push_back(pix_t'($urandom));
		end
	endtask

	// Wait until every pixel is in and every owed beat is out, then let the pipe settle.
	task automatic drain();
		while (pixel_q.size() > 0 || pix_valid || filtered_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int w, h, we, he, count, random_px, phase;
		for (int k = 0; k < MAX_WIDTH; k++) begin
			upper_mem[k]  = '0;
			middle_mem[k] = '0;
		end
		for (int k = 0; k < 6; k++)
			win[k] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest frame, all channels at full scale: largest possible sum
		set_frame(10'd3, 12'd3);
		idle_mode = IDLE_NONE;
		for (int k = 0; k < 9; k++)
			pixel_q.push_back(24'hFFFFFF);
		drain();

		// sizes below the minimum act as 3x3; alternating extreme patterns
		set_frame(10'd0, 12'd2);
		for (int k = 0; k < 9; k++)
			pixel_q.push_back((k % 2 == 0) ? 24'h00FF55 : 24'hFF00AA);
		drain();

		// tallest height register, partial frame left hanging before the next write
		set_frame(10'd1, 12'd4095);
		idle_mode = IDLE_BOTH;
		queue_random(40);
		drain();

		// width register above the line buffer size; start of a long first row
		set_frame(10'd1023, 12'd3);
		idle_mode = IDLE_RECV;
		queue_random(40);
		drain();

		// random small frames, all four idle patterns in turn
		random_px = 0;
		phase = 0;
		while (random_px < RANDOM_PIXELS) begin
			if ($urandom_range(5) == 0)
				w = int'($urandom_range(2));
			else if ($urandom_range(9) == 0)
				w = int'($urandom_range(10, 40));
			else
				w = int'($urandom_range(3, 9));
			h = ($urandom_range(5) == 0) ? int'($urandom_range(2)) :
				int'($urandom_range(3, 6));
			we = (w < MIN_DIM) ? MIN_DIM : w;
			he = (h < MIN_DIM) ? MIN_DIM : h;
			count = we * he * int'($urandom_range(1, 2));
			if ($urandom_range(4) == 0)
				count = int'($urandom_range(1, we * he - 1));  // stop mid-frame
			set_frame(10'(w), 12'(h));
			idle_mode = idle_mode_t'(phase % 4);
			queue_random(count);
			random_px += count;
			drain();
			phase++;
		end

		$display("Drove %0d pixels over %0d size settings; checked %0d result beats.",
			pixels_sent, settings_used, beats_checked);
		$display("Clamped 3x3 frames, extreme size registers and random small frames, "
			, "all idle patterns.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/bfrgb_pkg.sv
hw/rtl/bfrgb_ram.sv
hw/rtl/bfrgb_front.sv
hw/rtl/bfrgb_fifo.sv
hw/rtl/bfrgb_back.sv
hw/rtl/box_filter_3x3_rgb.sv
tb/box_filter_3x3_rgb_tb.sv
